// ===== design/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg: shared types, constants and functions of the Base64 decoder.
// Holds the alphabet lookup and the command word passed from the character
// front end to the byte back end.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Depth of the command queue between the front and back ends.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Lookup result width: six value bits and one flag for a non-alphabet byte.
  localparam int SextetW = 7;
  localparam logic [SextetW-1:0] SextetBad = 7'h40;

  // Character codes that need special handling.
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;

  // Number of pending sextets that triggers the byte emit cases.
  localparam logic [1:0] CntTwo   = 2'd2;
  localparam logic [1:0] CntThree = 2'd3;

  // One queued command: up to three bytes of one input transaction.
  typedef struct packed {
    logic [2:0][7:0] bytes;      // bytes[0] is emitted first
    logic [1:0]      last_idx;   // index of the final result of this command
    logic            has_bytes;  // 0 for the empty end marker
    logic            last;       // command closes the string
  } b64d_cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic      valid;
    b64d_cmd_t cmd;
  } b64d_head_t;

  // Maps one character to its sextet; bit 6 set marks a non-alphabet byte.
  function automatic logic [SextetW-1:0] sextet_of(input logic [7:0] ch);
    logic [7:0] diff;
    diff = 8'h00;
    if (ch >= ChUpperA && ch <= ChUpperZ) begin
      diff = ch - ChUpperA;
      return {1'b0, diff[5:0]};
    end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
      diff = ch - ChLowerA + 8'd26;
      return {1'b0, diff[5:0]};
    end else if (ch >= ChDigit0 && ch <= ChDigit9) begin
      diff = ch - ChDigit0 + 8'd52;
      return {1'b0, diff[5:0]};
    end else if (ch == ChPlus) begin
      return 7'd62;
    end else if (ch == ChSlash) begin
      return 7'd63;
    end
    return SextetBad;
  endfunction

endpackage

// ===== design/b64d_if.sv =====
// ----------------------------------------------------------------------------
// b64d_if: stream channels of the Base64 decoder.
// One channel carries encoded characters, the other decoded bytes; both use
// a valid/ready handshake with the payload alongside.
// ----------------------------------------------------------------------------

// Character channel.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       symbol_present;
  logic       end_of_string;

  modport source (output valid, output symbol, output symbol_present,
                  output end_of_string, input ready);
  modport sink   (input valid, input symbol, input symbol_present,
                  input end_of_string, output ready);
endinterface

// Decoded byte channel.
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid,
                  output last, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input last, output ready);
endinterface

// ===== design/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front: character front end.
// Classifies each character, collects sextets and turns every transaction
// that yields output into one command for the queue.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b64d_char_if.sink   chars,
  input  logic        q_full,
  output logic        push,
  output b64d_cmd_t   push_cmd
);

  logic [17:0]        store;
  logic [17:0]        store_next;
  logic [1:0]         cnt;
  logic [1:0]         cnt_next;
  logic               halted;
  logic               halted_next;
  logic [SextetW-1:0] sextet;
  logic [23:0]        grp;
  logic [1:0]         nres;
  logic               accept;

  assign chars.ready = !q_full;
  assign accept      = chars.valid && !q_full;
  assign sextet      = sextet_of(chars.symbol);
  assign grp         = {store, sextet[5:0]};

  // Symbol first, then the end-of-string flush on the updated state.
  always_comb begin
    store_next  = store;
    cnt_next    = cnt;
    halted_next = halted;
    nres        = 2'd0;
    push_cmd    = '0;
    push_cmd.has_bytes = 1'b1;

    if (chars.symbol_present && !halted) begin
      if (sextet[6]) begin
        halted_next = 1'b1;
      end else if (cnt == CntThree) begin
        push_cmd.bytes[0] = grp[23:16];
        push_cmd.bytes[1] = grp[15:8];
        push_cmd.bytes[2] = grp[7:0];
        nres       = 2'd3;
        store_next = '0;
        cnt_next   = 2'd0;
      end else begin
        store_next = {store[11:0], sextet[5:0]};
        cnt_next   = cnt + 2'd1;
      end
    end

    if (chars.end_of_string) begin
      if (cnt_next == CntTwo) begin
        push_cmd.bytes[0] = store_next[11:4];
        nres = 2'd1;
      end else if (cnt_next == CntThree) begin
        push_cmd.bytes[0] = store_next[17:10];
        push_cmd.bytes[1] = store_next[9:2];
        nres = 2'd2;
      end
      if (nres == 2'd0) begin
        push_cmd.has_bytes = 1'b0;
        nres = 2'd1;
      end
      push_cmd.last = 1'b1;
      store_next    = '0;
      cnt_next      = 2'd0;
      halted_next   = 1'b0;
    end

    push_cmd.last_idx = nres - 2'd1;
  end

  assign push = accept && (nres != 2'd0);

  // Sextet state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      store  <= '0;
      cnt    <= 2'd0;
      halted <= 1'b0;
    end else if (accept) begin
      store  <= store_next;
      cnt    <= cnt_next;
      halted <= halted_next;
    end
  end

endmodule

// ===== design/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue: command queue.
// A short first-in first-out buffer that decouples the front end from the
// back end so that each side may stall on its own.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64d_cmd_t   push_cmd,
  input  logic        pop,
  output logic        full,
  output b64d_head_t  head
);

  b64d_cmd_t          entries [QDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCntW-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == QCntW'(QDepth));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule

// ===== design/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back: byte back end.
// Walks through the bytes of the command at the queue head and presents
// them one per transaction from an output register.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  b64d_head_t  head,
  output logic        pop,
  b64d_byte_if.source decoded
);

  logic [1:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;
  logic       load;
  logic       take;
  logic       at_end;

  assign load   = !out_valid || decoded.ready;
  assign take   = load && head.valid;
  assign at_end = (idx == head.cmd.last_idx);
  assign pop    = take && at_end;

  assign decoded.valid      = out_valid;
  assign decoded.data_byte  = out_byte;
  assign decoded.byte_valid = out_byte_valid;
  assign decoded.last       = out_last;

  // Control: output valid and position within the current command.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= head.valid;
      end
      if (take) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte       <= head.cmd.has_bytes ? head.cmd.bytes[idx] : 8'h00;
      out_byte_valid <= head.cmd.has_bytes;
      out_last       <= head.cmd.last && at_end;
    end
  end

endmodule

// ===== design/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming Base64 decoder, standard alphabet.
// Takes one character per transaction and delivers decoded bytes, one per
// transaction, with the final result of each string marked.
// ----------------------------------------------------------------------------
// The decoder takes one character every clock cycle while the queue is not
// full. A front end classifies each character and, whenever a transaction
// completes a group of four sextets or ends the string, writes a command of
// up to three bytes into a four-entry queue; a back end sends those bytes
// out one per cycle from an output register while the sink accepts them.
// The sustained rate is therefore one character per cycle; the input stalls
// only when the output is held off long enough to fill the queue. A byte
// passes through the queue and then the output register. The first
// '=' or other character outside the alphabet stops decoding until the
// end-of-string transaction, which flushes a partial group and returns the
// decoder to its reset state. A string that ends with nothing to emit
// produces one result with byte_valid low and last high.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b64d_char_if.sink   chars,
  b64d_byte_if.source decoded
);

  logic       push;
  b64d_cmd_t  push_cmd;
  logic       q_full;
  logic       pop;
  b64d_head_t head;

  // Character classification and sextet collection.
  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decoupling queue.
  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // Byte serializer and output register.
  b64d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

// ===== design/b64d_checker.sv =====
// ----------------------------------------------------------------------------
// b64d_checker: port-level checks of the Base64 decoder.
// Watches the byte channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic       out_last
);

  // A result held off by the sink stays offered.
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("decoded valid dropped while stalled");

  // A stalled result keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(out_data_byte) && $stable(out_byte_valid) && $stable(out_last))
    else $error("decoded payload changed while stalled");

  // An empty result only ever closes a string.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_byte_valid |-> out_last)
    else $error("empty result without last");

  // An empty result carries a zero byte.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_byte_valid |-> out_data_byte == 8'h00)
    else $error("empty result with nonzero byte");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (decoded.valid),
  .out_ready      (decoded.ready),
  .out_data_byte  (decoded.data_byte),
  .out_byte_valid (decoded.byte_valid),
  .out_last       (decoded.last)
);
